### hdl/mlp_pkg.sv
// Shared types and constants for the perceptron inference engine.
// No dependencies; imported by mlp_cell, mlp_ctrl and mlp_inference_engine.
`timescale 1ns / 1ps

package mlp_pkg;

    // Item kinds carried on the mode field
    typedef enum logic [1:0] {
        MODE_WEIGHT  = 2'd0,
        MODE_BIAS    = 2'd1,
        MODE_FEATURE = 2'd2
    } mode_t;

    // Layer codes, same encoding as the layer field
    typedef enum logic [1:0] {
        LAYER_1 = 2'd0,
        LAYER_2 = 2'd1,
        LAYER_3 = 2'd2
    } layer_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_ISSUE,
        ST_DRAIN,
        ST_LOAD,
        ST_SHIFT
    } state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;
    localparam logic [1:0] CFG_CLASS_COUNT  = 2'd2;

    // Network size limits; the field widths below are sized for them
    localparam int MAX_INPUTS  = 1024;
    localparam int MAX_HIDDEN  = 128;
    localparam int MAX_CLASSES = 16;

    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 11;
    localparam int INPUT_COUNT_W   = 11;
    localparam int HIDDEN_COUNT_W  = 8;
    localparam int CLASS_COUNT_W   = 5;
    localparam int ROW_W           = 10;
    localparam int COL_W           = 7;
    localparam int CLASS_W         = 4;

    localparam logic [INPUT_COUNT_W-1:0]  INPUT_COUNT_RST  = 11'd484;
    localparam logic [HIDDEN_COUNT_W-1:0] HIDDEN_COUNT_RST = 8'd100;
    localparam logic [CLASS_COUNT_W-1:0]  CLASS_COUNT_RST  = 5'd10;

    // Q.20 sum back to Q8.8, and Q4.12 bias up to Q.20
    localparam int FRAC_SHIFT = 12;
    localparam int BIAS_SHIFT = 8;

    // Weight or bias write broadcast to the cell row
    typedef struct packed {
        logic   en;
        logic   bias;
        layer_t layer;
    } wr_ctrl_t;

    // Per-layer controls shared by every cell
    typedef struct packed {
        logic   start;
        logic   load;
        logic   shift;
        layer_t layer;
    } cell_ctrl_t;

endpackage

### hdl/mlp_cell.sv
// One MAC cell of the row: owns the weight column and bias of its unit.
// Depends on mlp_pkg; instantiated by mlp_inference_engine.
`timescale 1ns / 1ps

module mlp_cell #(
    parameter int CELL_INDEX = 0,
    parameter int DATA_WIDTH = 16,
    parameter int SAW        = 10,
    parameter int ACC_W      = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlp_pkg::cell_ctrl_t         ctrl,
    input  mlp_pkg::wr_ctrl_t           wr,
    input  logic [SAW-1:0]              wr_addr,
    input  logic [mlp_pkg::COL_W-1:0]   wr_col,
    input  logic [DATA_WIDTH-1:0]       wr_data,
    input  logic                        x_valid,
    input  logic [SAW-1:0]              x_addr,
    input  logic [DATA_WIDTH-1:0]       x_data,
    output logic                        nxt_valid,
    output logic [SAW-1:0]              nxt_addr,
    output logic [DATA_WIDTH-1:0]       nxt_data,
    input  logic [DATA_WIDTH-1:0]       shift_in,
    output logic [DATA_WIDTH-1:0]       unit_out
);
    import mlp_pkg::*;

    localparam int AW_I = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int AW_H = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int PW   = 2 * DATA_WIDTH;
    localparam int QW   = ACC_W - FRAC_SHIFT;
    localparam logic signed [QW-1:0] QMAX = {{(QW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {{(QW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic [DATA_WIDTH-1:0] w1_mem [MAX_INPUTS];
    logic [DATA_WIDTH-1:0] w2_mem [MAX_HIDDEN];
    logic [DATA_WIDTH-1:0] w3_mem [MAX_HIDDEN];
    logic [DATA_WIDTH-1:0] b1_reg, b2_reg, b3_reg;
    logic [DATA_WIDTH-1:0] w1_rd_reg, w2_rd_reg, w3_rd_reg;

    logic                  a_valid_reg;
    logic [SAW-1:0]        a_addr_reg;
    logic [DATA_WIDTH-1:0] a_data_reg;
    logic                  p_valid_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] unit_reg;

    logic                  sel;
    logic [DATA_WIDTH-1:0] w_cur;
    logic [DATA_WIDTH-1:0] b_cur;
    logic signed [ACC_W-1:0] bias_ext;
    logic signed [QW-1:0]  q;
    logic [DATA_WIDTH-1:0] sat;
    logic [DATA_WIDTH-1:0] fin;

    assign sel = (32'(wr_col) == CELL_INDEX);

    // Weight and bias stores, registered weight reads
    always_ff @(posedge clk)
    begin
        if (wr.en && sel) begin
            if (wr.bias) begin
                case (wr.layer)
                    LAYER_1: b1_reg <= wr_data;
                    LAYER_2: b2_reg <= wr_data;
                    LAYER_3: b3_reg <= wr_data;
                    default: ;
                endcase
            end else begin
                case (wr.layer)
                    LAYER_1: w1_mem[wr_addr[AW_I-1:0]] <= wr_data;
                    LAYER_2: w2_mem[wr_addr[AW_H-1:0]] <= wr_data;
                    LAYER_3: w3_mem[wr_addr[AW_H-1:0]] <= wr_data;
                    default: ;
                endcase
            end
        end
        w1_rd_reg <= w1_mem[x_addr[AW_I-1:0]];
        w2_rd_reg <= w2_mem[x_addr[AW_H-1:0]];
        w3_rd_reg <= w3_mem[x_addr[AW_H-1:0]];
    end

    // Select weight and bias of the running layer
    always_comb
    begin
        case (ctrl.layer)
            LAYER_1: begin w_cur = w1_rd_reg; b_cur = b1_reg; end
            LAYER_2: begin w_cur = w2_rd_reg; b_cur = b2_reg; end
            default: begin w_cur = w3_rd_reg; b_cur = b3_reg; end
        endcase
        bias_ext = ACC_W'($signed(b_cur)) <<< BIAS_SHIFT;
    end

    // Floor shift, saturate, ReLU on hidden layers
    always_comb
    begin
        q = acc_reg[ACC_W-1:FRAC_SHIFT];
        if (q > QMAX)
            sat = QMAX[DATA_WIDTH-1:0];
        else if (q < QMIN)
            sat = QMIN[DATA_WIDTH-1:0];
        else
            sat = q[DATA_WIDTH-1:0];
        if (ctrl.layer != LAYER_3 && sat[DATA_WIDTH-1])
            fin = '0;
        else
            fin = sat;
    end

    // Stream stage handed to the neighbor, then multiply, then accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= x_valid;
            p_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg <= x_addr;
        a_data_reg <= x_data;
        prod_reg   <= $signed(a_data_reg) * $signed(w_cur);
        if (ctrl.start)
            acc_reg <= bias_ext;
        else if (p_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (ctrl.load)
            unit_reg <= fin;
        else if (ctrl.shift)
            unit_reg <= shift_in;
    end

    assign nxt_valid = a_valid_reg;
    assign nxt_addr  = a_addr_reg;
    assign nxt_data  = a_data_reg;
    assign unit_out  = unit_reg;

endmodule

### hdl/mlp_ctrl.sv
// Sequencer: item decode, configuration, feature and hidden stores, argmax.
// Depends on mlp_pkg; instantiated by mlp_inference_engine.
`timescale 1ns / 1ps

module mlp_ctrl #(
    parameter int DATA_WIDTH  = 16,
    parameter int NCELL       = 128,
    parameter int SAW         = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mlp_pkg::CFG_INDEX_W-1:0]   cfg_addr,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              start,
    input  logic [1:0]                        mode,
    input  logic [1:0]                        layer,
    input  logic [mlp_pkg::ROW_W-1:0]         row_index,
    input  logic [mlp_pkg::COL_W-1:0]         column_index,
    input  logic [DATA_WIDTH-1:0]             value,
    input  logic                              last,
    output logic                              busy,
    output logic                              done,
    output logic [mlp_pkg::CLASS_W-1:0]       predicted_class,
    output logic [DATA_WIDTH-1:0]             best_score,
    output mlp_pkg::cell_ctrl_t               cell_ctrl,
    output mlp_pkg::wr_ctrl_t                 wr,
    output logic [SAW-1:0]                    wr_addr,
    output logic [mlp_pkg::COL_W-1:0]         wr_col,
    output logic [DATA_WIDTH-1:0]             wr_data,
    output logic                              src_valid,
    output logic [SAW-1:0]                    src_addr,
    output logic [DATA_WIDTH-1:0]             src_data,
    input  logic [DATA_WIDTH-1:0]             head_unit
);
    import mlp_pkg::*;

    localparam int AW_I  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int AW_H  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int NIW   = $clog2(MAX_INPUTS + 1);
    localparam int NHW   = $clog2(MAX_HIDDEN + 1);
    localparam int NCW   = $clog2(MAX_CLASSES + 1);
    localparam int KW    = (NIW > NHW) ? NIW : NHW;
    localparam int DRAIN = NCELL + 6;
    localparam int CW    = $clog2(DRAIN + 1);

    logic [INPUT_COUNT_W-1:0]  in_cnt_reg;
    logic [HIDDEN_COUNT_W-1:0] hid_cnt_reg;
    logic [CLASS_COUNT_W-1:0]  cls_cnt_reg;

    logic [DATA_WIDTH-1:0] feat_mem [MAX_INPUTS];
    logic [DATA_WIDTH-1:0] hid_mem  [MAX_HIDDEN];
    logic [DATA_WIDTH-1:0] feat_rd_reg, hid_rd_reg;

    state_t state_reg, state_next;
    layer_t lyr_reg, lyr_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           issue_v_reg;
    logic [SAW-1:0] src_addr_reg;
    logic                  done_reg, done_next;
    logic [CW-1:0]         best_idx_reg, best_idx_next;
    logic [DATA_WIDTH-1:0] best_reg, best_next;
    logic [CLASS_W-1:0]    class_reg;

    logic [NIW-1:0] ni;
    logic [NHW-1:0] nh;
    logic [NCW-1:0] nc;
    logic [KW-1:0]  n_src;
    logic [CW-1:0]  n_dst;
    logic accept, kick;
    logic row_ok_i, row_ok_h, col_ok_h, col_ok_c;
    logic w_ok, b_ok;
    logic take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_cnt_reg  <= INPUT_COUNT_RST;
            hid_cnt_reg <= HIDDEN_COUNT_RST;
            cls_cnt_reg <= CLASS_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_INPUT_COUNT:  in_cnt_reg  <= cfg_wdata[INPUT_COUNT_W-1:0];
                CFG_HIDDEN_COUNT: hid_cnt_reg <= cfg_wdata[HIDDEN_COUNT_W-1:0];
                CFG_CLASS_COUNT:  cls_cnt_reg <= cfg_wdata[CLASS_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Counts clamped to 1..max
    always_comb
    begin
        if (in_cnt_reg == '0)
            ni = NIW'(1);
        else if (32'(in_cnt_reg) > MAX_INPUTS)
            ni = NIW'(MAX_INPUTS);
        else
            ni = NIW'(in_cnt_reg);
        if (hid_cnt_reg == '0)
            nh = NHW'(1);
        else if (32'(hid_cnt_reg) > MAX_HIDDEN)
            nh = NHW'(MAX_HIDDEN);
        else
            nh = NHW'(hid_cnt_reg);
        if (cls_cnt_reg == '0)
            nc = NCW'(1);
        else if (32'(cls_cnt_reg) > MAX_CLASSES)
            nc = NCW'(MAX_CLASSES);
        else
            nc = NCW'(cls_cnt_reg);
    end

    // Item decode and write broadcast
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign kick     = accept && (mode == MODE_FEATURE) && last;
    assign row_ok_i = (32'(row_index) < MAX_INPUTS);
    assign row_ok_h = (32'(row_index) < MAX_HIDDEN);
    assign col_ok_h = (32'(column_index) < MAX_HIDDEN);
    assign col_ok_c = (32'(column_index) < MAX_CLASSES);
    assign w_ok = (layer == LAYER_1 && row_ok_i && col_ok_h)
               || (layer == LAYER_2 && row_ok_h && col_ok_h)
               || (layer == LAYER_3 && row_ok_h && col_ok_c);
    assign b_ok = ((layer == LAYER_1 || layer == LAYER_2) && col_ok_h)
               || (layer == LAYER_3 && col_ok_c);

    always_comb
    begin
        wr.en    = accept && ((mode == MODE_WEIGHT && w_ok) || (mode == MODE_BIAS && b_ok));
        wr.bias  = (mode == MODE_BIAS);
        wr.layer = layer_t'(layer);
    end
    assign wr_addr = SAW'(row_index);
    assign wr_col  = column_index;
    assign wr_data = value;

    // Feature and hidden stores
    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_FEATURE && row_ok_i)
            feat_mem[row_index[AW_I-1:0]] <= value;
        if (state_reg == ST_SHIFT && lyr_reg != LAYER_3)
            hid_mem[cnt_reg[AW_H-1:0]] <= head_unit;
        feat_rd_reg  <= feat_mem[k_reg[AW_I-1:0]];
        hid_rd_reg   <= hid_mem[k_reg[AW_H-1:0]];
        src_addr_reg <= SAW'(k_reg);
    end

    assign src_valid = issue_v_reg;
    assign src_addr  = src_addr_reg;
    assign src_data  = (lyr_reg == LAYER_1) ? feat_rd_reg : hid_rd_reg;

    // Running argmax over the shifted-out class scores
    assign take = (cnt_reg == '0) || ($signed(head_unit) > $signed(best_reg));

    always_comb
    begin
        n_src = (lyr_reg == LAYER_1) ? KW'(ni) : KW'(nh);
        n_dst = (lyr_reg == LAYER_3) ? CW'(nc) : CW'(nh);
        state_next    = state_reg;
        lyr_next      = lyr_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        cell_ctrl.start = (state_reg == ST_BIAS);
        cell_ctrl.load  = (state_reg == ST_LOAD);
        cell_ctrl.shift = (state_reg == ST_SHIFT);
        cell_ctrl.layer = lyr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (kick) begin
                    lyr_next   = LAYER_1;
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS: begin
                k_next     = '0;
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                k_next = k_reg + 1'b1;
                if (k_reg == n_src - 1'b1) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DRAIN - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cnt_next   = '0;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cnt_next = cnt_reg + 1'b1;
                if (lyr_reg == LAYER_3 && take) begin
                    best_idx_next = cnt_reg;
                    best_next     = head_unit;
                end
                if (cnt_reg == n_dst - 1'b1) begin
                    case (lyr_reg)
                        LAYER_1: begin lyr_next = LAYER_2; state_next = ST_BIAS; end
                        LAYER_2: begin lyr_next = LAYER_3; state_next = ST_BIAS; end
                        default: begin done_next = 1'b1; state_next = ST_IDLE; end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            lyr_reg     <= LAYER_1;
            k_reg       <= '0;
            cnt_reg     <= '0;
            issue_v_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lyr_reg     <= lyr_next;
            k_reg       <= k_next;
            cnt_reg     <= cnt_next;
            issue_v_reg <= (state_reg == ST_ISSUE);
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        if (done_next)
            class_reg <= CLASS_W'(best_idx_next);
    end

    assign done            = done_reg;
    assign predicted_class = class_reg;
    assign best_score      = best_reg;

endmodule

### hdl/mlp_inference_engine.sv
// Top level: sequencer plus a row of MAC cells that pass the stream along.
// Depends on mlp_pkg, mlp_cell and mlp_ctrl.
//
//  channel   signals                                          handshake
//  config    cfg_we, cfg_addr, cfg_wdata                      write when cfg_we
//  item      mode, layer, row_index, column_index, value, last accepted at start && !busy
//  result    predicted_class, best_score                      one-cycle done strobe
//
// Weight, bias and plain feature items are taken without raising busy. A feature marked
// last raises busy while each layer loads its biases, streams its inputs one per cycle
// into the head of the cell row, drains the row, then shifts the unit results back out
// through the head cell.
// done pulses in the same cycle that busy falls.
// Reset clears control and loads size defaults; stores are undefined until written.
// Results cannot be stalled: done pulses for one cycle.
`timescale 1ns / 1ps

module mlp_inference_engine #(
    parameter int DATA_WIDTH  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mlp_pkg::CFG_INDEX_W-1:0]   cfg_addr,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [1:0]                        layer,
    input  logic [mlp_pkg::ROW_W-1:0]         row_index,
    input  logic [mlp_pkg::COL_W-1:0]         column_index,
    input  logic [DATA_WIDTH-1:0]             value,
    input  logic                              last,
    output logic                              done,
    output logic [mlp_pkg::CLASS_W-1:0]       predicted_class,
    output logic [DATA_WIDTH-1:0]             best_score
);
    import mlp_pkg::*;

    localparam int AW_I    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int AW_H    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int SAW     = (AW_I > AW_H) ? AW_I : AW_H;
    localparam int NCELL   = (MAX_HIDDEN > MAX_CLASSES) ? MAX_HIDDEN : MAX_CLASSES;
    localparam int ACC_RAW = 2 * DATA_WIDTH + AW_I + 6;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;

    cell_ctrl_t            cell_ctrl;
    wr_ctrl_t              wr;
    logic [SAW-1:0]        wr_addr;
    logic [COL_W-1:0]      wr_col;
    logic [DATA_WIDTH-1:0] wr_data;

    logic                  chain_valid [NCELL+1];
    logic [SAW-1:0]        chain_addr  [NCELL+1];
    logic [DATA_WIDTH-1:0] chain_data  [NCELL+1];
    logic [DATA_WIDTH-1:0] unit_val    [NCELL+1];

    mlp_ctrl #(
        .DATA_WIDTH  (DATA_WIDTH),
        .NCELL       (NCELL),
        .SAW         (SAW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .mode            (mode),
        .layer           (layer),
        .row_index       (row_index),
        .column_index    (column_index),
        .value           (value),
        .last            (last),
        .busy            (busy),
        .done            (done),
        .predicted_class (predicted_class),
        .best_score      (best_score),
        .cell_ctrl       (cell_ctrl),
        .wr              (wr),
        .wr_addr         (wr_addr),
        .wr_col          (wr_col),
        .wr_data         (wr_data),
        .src_valid       (chain_valid[0]),
        .src_addr        (chain_addr[0]),
        .src_data        (chain_data[0]),
        .head_unit       (unit_val[0])
    );

    // Tail of the shift chain feeds zeros
    assign unit_val[NCELL] = '0;

    // Row of cells, stream moves one cell per cycle
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        mlp_cell #(
            .CELL_INDEX (j),
            .DATA_WIDTH (DATA_WIDTH),
            .SAW        (SAW),
            .ACC_W      (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .wr        (wr),
            .wr_addr   (wr_addr),
            .wr_col    (wr_col),
            .wr_data   (wr_data),
            .x_valid   (chain_valid[j]),
            .x_addr    (chain_addr[j]),
            .x_data    (chain_data[j]),
            .nxt_valid (chain_valid[j+1]),
            .nxt_addr  (chain_addr[j+1]),
            .nxt_data  (chain_data[j+1]),
            .shift_in  (unit_val[j+1]),
            .unit_out  (unit_val[j])
        );
    end

endmodule

### dv/tb_mlp_inference_engine.sv
// Self-checking testbench for mlp_inference_engine: loads weights, biases and features,
// predicts each classification with its own fixed-point network model. Depends on mlp_pkg.
`timescale 1ns / 1ps

module tb_mlp_inference_engine;

    import mlp_pkg::*;

    localparam int NIN  = 1024;
    localparam int NHID = 128;
    localparam int NCLS = 16;

    // Codes the block ignores
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] LAYER_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [1:0]  layer;
        logic [9:0]  row;
        logic [6:0]  col;
        logic [15:0] val;
        logic        last;
    } item_t;

    typedef struct {
        logic [3:0]  cls;
        logic [15:0] score;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [10:0] cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = '0;
    logic [1:0]  layer = '0;
    logic [9:0]  row_index = '0;
    logic [6:0]  column_index = '0;
    logic [15:0] value = '0;
    logic        last = 1'b0;
    logic        done;
    logic [3:0]  predicted_class;
    logic [15:0] best_score;

    mlp_inference_engine u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .start(start), .busy(busy), .mode(mode),
        .layer(layer), .row_index(row_index), .column_index(column_index),
        .value(value), .last(last), .done(done),
        .predicted_class(predicted_class), .best_score(best_score)
    );

    // Shadow network state
    logic signed [15:0] feat_mem [NIN];
    logic signed [15:0] w1_mem [NIN*NHID];
    logic signed [15:0] w2_mem [NHID*NHID];
    logic signed [15:0] w3_mem [NHID*NCLS];
    logic signed [15:0] b1_mem [NHID];
    logic signed [15:0] b2_mem [NHID];
    logic signed [15:0] b3_mem [NCLS];
    int hid1 [NHID];
    int hid2 [NHID];
    int in_reg = 484;
    int hid_reg = 100;
    int cls_reg = 10;

    item_t    pending_items[$];
    verdict_t expected_verdicts[$];
    int gap = 0;
    bit idle_on = 1'b1;
    int errors = 0;
    int n_items = 0;
    int n_results = 0;

    initial forever #5 clk = ~clk;

    function automatic int clampi(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Q.20 sum to Q8.8: floor shift then saturate
    function automatic int unit_out(longint acc);
        longint q;
        q = acc >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic void classify();
        int ni, nh, nc, r, best, best_val;
        longint acc;
        verdict_t v;
        ni = clampi(in_reg, NIN);
        nh = clampi(hid_reg, NHID);
        nc = clampi(cls_reg, NCLS);
        best = 0;
        best_val = 0;
        for (int j = 0; j < nh; j++)
        begin
            acc = longint'(b1_mem[j]) <<< 8;
            for (int k = 0; k < ni; k++)
                acc += longint'(feat_mem[k]) * longint'(w1_mem[k*NHID+j]);
            r = unit_out(acc);
            hid1[j] = (r < 0) ? 0 : r;
        end
        for (int j = 0; j < nh; j++)
        begin
            acc = longint'(b2_mem[j]) <<< 8;
            for (int k = 0; k < nh; k++)
                acc += longint'(hid1[k]) * longint'(w2_mem[k*NHID+j]);
            r = unit_out(acc);
            hid2[j] = (r < 0) ? 0 : r;
        end
        for (int j = 0; j < nc; j++)
        begin
            acc = longint'(b3_mem[j]) <<< 8;
            for (int k = 0; k < nh; k++)
                acc += longint'(hid2[k]) * longint'(w3_mem[k*NCLS+j]);
            r = unit_out(acc);
            if (j == 0 || r > best_val)
            begin
                best = j;
                best_val = r;
            end
        end
        v.cls = best[3:0];
        v.score = best_val[15:0];
        expected_verdicts.push_back(v);
    endfunction

    // Apply one accepted transaction to the shadow state
    function automatic void apply_item(item_t it);
        int r, c;
        r = it.row;
        c = it.col;
        if (it.mode == MODE_WEIGHT)
        begin
            if (it.layer == LAYER_1) w1_mem[r*NHID+c] = it.val;
            else if (it.layer == LAYER_2 && r < NHID) w2_mem[r*NHID+c] = it.val;
            else if (it.layer == LAYER_3 && r < NHID && c < NCLS) w3_mem[r*NCLS+c] = it.val;
        end
        else if (it.mode == MODE_BIAS)
        begin
            if (it.layer == LAYER_1) b1_mem[c] = it.val;
            else if (it.layer == LAYER_2) b2_mem[c] = it.val;
            else if (it.layer == LAYER_3 && c < NCLS) b3_mem[c] = it.val;
        end
        else if (it.mode == MODE_FEATURE)
        begin
            feat_mem[r] = it.val;
            if (it.last) classify();
        end
    endfunction

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    task automatic push(logic [1:0] m, logic [1:0] l, int r, int c, logic [15:0] v,
                        logic lst);
        item_t it;
        it.mode = m;
        it.layer = l;
        it.row = r[9:0];
        it.col = c[6:0];
        it.val = v;
        it.last = lst;
        pending_items.push_back(it);
    endtask

    // Wait for the block to go quiet, then write a register
    task automatic write_reg(logic [1:0] idx, int v);
        while (pending_items.size() != 0 || start || expected_verdicts.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = v[10:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_INPUT_COUNT: in_reg = v & 11'h7FF;
            CFG_HIDDEN_COUNT: hid_reg = v & 8'hFF;
            default: cls_reg = v & 5'h1F;
        endcase
    endtask

    task automatic set_sizes(int ni, int nh, int nc);
        write_reg(CFG_INPUT_COUNT, ni);
        write_reg(CFG_HIDDEN_COUNT, nh);
        write_reg(CFG_CLASS_COUNT, nc);
    endtask

    // Fill every entry the current sizes read
    task automatic load_all();
        int ni, nh, nc;
        ni = clampi(in_reg, NIN);
        nh = clampi(hid_reg, NHID);
        nc = clampi(cls_reg, NCLS);
        for (int k = 0; k < ni; k++)
            for (int j = 0; j < nh; j++) push(MODE_WEIGHT, LAYER_1, k, j, pick_val(), 1'b0);
        for (int k = 0; k < nh; k++)
            for (int j = 0; j < nh; j++) push(MODE_WEIGHT, LAYER_2, k, j, pick_val(), 1'b0);
        for (int k = 0; k < nh; k++)
            for (int j = 0; j < nc; j++) push(MODE_WEIGHT, LAYER_3, k, j, pick_val(), 1'b0);
        for (int j = 0; j < nh; j++) push(MODE_BIAS, LAYER_1, 0, j, pick_val(), 1'b0);
        for (int j = 0; j < nh; j++) push(MODE_BIAS, LAYER_2, 0, j, pick_val(), 1'b0);
        for (int j = 0; j < nc; j++) push(MODE_BIAS, LAYER_3, 0, j, pick_val(), 1'b0);
        for (int k = 0; k < ni; k++) push(MODE_FEATURE, LAYER_1, k, 0, pick_val(), 1'b0);
    endtask

    // Mostly in-range writes and feature streams; some raw noise
    task automatic random_items(int count);
        int ni, nh, nc, sel, l;
        ni = clampi(in_reg, NIN);
        nh = clampi(hid_reg, NHID);
        nc = clampi(cls_reg, NCLS);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            l = $urandom_range(0, 2);
            if (sel < 25)
                push(MODE_WEIGHT, l[1:0], $urandom_range(0, (l == 0) ? ni - 1 : nh - 1),
                     $urandom_range(0, (l == 2) ? nc - 1 : nh - 1), pick_val(), 1'b0);
            else if (sel < 35)
                push(MODE_BIAS, l[1:0], 0, $urandom_range(0, (l == 2) ? nc - 1 : nh - 1),
                     pick_val(), 1'b0);
            else if (sel < 88)
                push(MODE_FEATURE, LAYER_1, $urandom_range(0, ni - 1), 0, pick_val(),
                     $urandom_range(0, 4) == 0);
            else
                push(2'($urandom), 2'($urandom), $urandom_range(0, 1023),
                     $urandom_range(0, 127), 16'($urandom), 1'($urandom));
        end
    endtask

    // Driver: present the oldest pending transaction at the falling edge
    always @(negedge clk)
    begin
        if (gap > 0)
        begin
            start <= 1'b0;
            gap--;
        end
        else if (pending_items.size() > 0)
        begin
            start <= 1'b1;
            mode <= pending_items[0].mode;
            layer <= pending_items[0].layer;
            row_index <= pending_items[0].row;
            column_index <= pending_items[0].col;
            value <= pending_items[0].val;
            last <= pending_items[0].last;
        end
        else
            start <= 1'b0;
    end

    // Monitor: accepted transactions feed the model, results get checked
    always @(posedge clk)
    begin
        item_t it;
        verdict_t ev;
        if (rst_n && start && !busy)
        begin
            it.mode = mode;
            it.layer = layer;
            it.row = row_index;
            it.col = column_index;
            it.val = value;
            it.last = last;
            apply_item(it);
            pending_items.pop_front();
            n_items++;
            if (idle_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 12);
        end
        if (rst_n && done)
        begin
            n_results++;
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result class %0d score %0d", $time,
                         predicted_class, $signed(best_score));
            end
            else
            begin
                ev = expected_verdicts.pop_front();
                if (ev.cls !== predicted_class)
                begin
                    errors++;
                    $display("%0t: predicted_class expected %0d actual %0d", $time,
                             ev.cls, predicted_class);
                end
                if (ev.score !== best_score)
                begin
                    errors++;
                    $display("%0t: best_score expected %0d actual %0d", $time,
                             $signed(ev.score), $signed(best_score));
                end
            end
        end
    end

    initial
    begin
        int nh, nc;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Small net with directed corners
        set_sizes(3, 4, 3);
        load_all();
        push(MODE_FEATURE, LAYER_1, 0, 0, 16'h7FFF, 1'b0);
        push(MODE_FEATURE, LAYER_1, 1, 0, 16'h8000, 1'b0);
        push(MODE_FEATURE, LAYER_1, 2, 0, 16'h7FFF, 1'b1);
        // Tie across all classes: lowest index wins
        for (int k = 0; k < 4; k++)
            for (int j = 0; j < 3; j++) push(MODE_WEIGHT, LAYER_3, k, j, 16'h0000, 1'b0);
        for (int j = 0; j < 3; j++) push(MODE_BIAS, LAYER_3, 0, j, 16'h0000, 1'b0);
        push(MODE_FEATURE, LAYER_1, 1023, 0, 16'h8000, 1'b1);
        // Ignored items: spare mode, spare layer, last on a write, out-of-range addresses
        push(MODE_SPARE, LAYER_1, 0, 0, 16'h1234, 1'b1);
        push(MODE_WEIGHT, LAYER_SPARE, 0, 0, 16'h1234, 1'b1);
        push(MODE_BIAS, LAYER_3, 0, 100, 16'h7FFF, 1'b1);
        push(MODE_WEIGHT, LAYER_2, 1023, 0, 16'h7FFF, 1'b0);
        push(MODE_FEATURE, LAYER_1, 0, 0, 16'h0000, 1'b1);
        random_items(200);

        // Zero counts as one
        set_sizes(0, 0, 0);
        load_all();
        random_items(100);

        // Class count above range clamps to the maximum
        set_sizes(2, 1, 31);
        load_all();
        random_items(100);

        // Mixed sizes, then a final stretch with no idling
        nh = $urandom_range(2, 8);
        nc = $urandom_range(2, 16);
        set_sizes($urandom_range(2, 12), nh, nc);
        load_all();
        random_items(300);
        while (pending_items.size() != 0) @(posedge clk);
        idle_on = 1'b0;
        random_items(200);

        while (pending_items.size() != 0 || expected_verdicts.size() != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d transactions and %0d classifications over four size settings,",
                 n_items, n_results);
        $display("including zero and over-range sizes, saturation, ties and ignored items.");
        if (errors == 0)
            $display("mlp_inference_engine test passed");
        else
            $display("mlp_inference_engine test failed");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("mlp_inference_engine test failed");
        $finish;
    end

endmodule
